@@ hw/rtl/cgtf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgtf_pkg: shared types and constants of the 4bpp palette texel fetch
// Operation codes, register indexes, stage structs and the channel widening.
// ----------------------------------------------------------------------------
package cgtf_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;
  localparam int SideW    = 7;
  localparam int CoordW   = 6;
  localparam int RowOffW  = 13;
  localparam int FetchW   = 14;
  localparam int PalIdxW  = 4;
  localparam int ColorW   = 16;
  localparam int ByteAddrW = 11;
  localparam int ChanW    = 8;

  typedef enum logic [1:0] {
    OP_PAL_WR = 2'd0,
    OP_BMP_WR = 2'd1,
    OP_FETCH  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH      = 2'd0,
    CFG_HEIGHT     = 2'd1,
    CFG_TRANSPOSED = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic fetch;
    logic oor;
    logic odd;
  } fetch_req_t;

  typedef struct packed {
    logic                 wr;
    logic [PalIdxW-1:0]   idx;
    logic [ColorW-1:0]    color;
  } pal_wr_t;

  function automatic logic [ChanW-1:0] widen5(logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/clut4_glyph_texel_fetch_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clut4_glyph_texel_fetch_top: 4bpp palette glyph texel fetch
// Commands load a 16-entry 15-bit palette and a 4bpp bitmap, and fetch
// destination pixels as widened RGBA.
//
// Usage:
//   Command channel: a transfer happens on a clock edge with start_i high and
//   busy_o low. busy_o is always low: one command per clock.
//   op_i selects palette write, bitmap byte write or pixel fetch.
//   Configuration: cfg_we_i writes width, height or transposed mode; write
//   only while no fetch is in flight.
//   Results: a fetch's result passes the fetch stage and result registers and
//   is shown for one cycle with done_o high. Writes give no result.
//   Throughput: one command per cycle, set by the single read port of the
//   bitmap RAM and the one-stage palette lookup behind it.
//   The receiver cannot stall: results must be taken when done_o is high.
//   Reset clears the geometry to a 1x1 untransposed glyph and empties the
//   pipeline; palette and bitmap contents stay undefined until written.
// ----------------------------------------------------------------------------
module clut4_glyph_texel_fetch_top #(
  parameter int STORE_BYTES = 2048
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cgtf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [cgtf_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        op_i,
  input  wire logic [cgtf_pkg::PalIdxW-1:0]      palette_index_i,
  input  wire logic [cgtf_pkg::ColorW-1:0]       color_word_i,
  input  wire logic [cgtf_pkg::ByteAddrW-1:0]    byte_address_i,
  input  wire logic [7:0]                        byte_value_i,
  input  wire logic [cgtf_pkg::CoordW-1:0]       dest_x_i,
  input  wire logic [cgtf_pkg::CoordW-1:0]       dest_y_i,
  output logic                                   done_o,
  output logic [cgtf_pkg::ChanW-1:0]             red_o,
  output logic [cgtf_pkg::ChanW-1:0]             green_o,
  output logic [cgtf_pkg::ChanW-1:0]             blue_o,
  output logic [cgtf_pkg::ChanW-1:0]             alpha_o,
  output logic                                   out_of_range_o
);
  import cgtf_pkg::*;

  localparam int AddrW = $clog2(STORE_BYTES);

  logic             accept;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  fetch_req_t       fetch;
  pal_wr_t          pal_wr;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  cgtf_front #(
    .StoreBytes(STORE_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .op_i           (op_i),
    .palette_index_i(palette_index_i),
    .color_word_i   (color_word_i),
    .byte_address_i (byte_address_i),
    .byte_value_i   (byte_value_i),
    .dest_x_i       (dest_x_i),
    .dest_y_i       (dest_y_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .fetch_o        (fetch),
    .pal_wr_o       (pal_wr)
  );

  cgtf_ram #(
    .Width(8),
    .Depth(STORE_BYTES)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cgtf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fetch_i       (fetch),
    .pal_wr_i      (pal_wr),
    .ram_rdata_i   (ram_rdata),
    .done_o        (done_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .out_of_range_o(out_of_range_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/cgtf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgtf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cgtf_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hw/rtl/cgtf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgtf_front: geometry registers and fetch address generation
// Holds the glyph size and orientation, decodes the command, forms the
// bitmap byte address and the range check for a fetch.
// ----------------------------------------------------------------------------
module cgtf_front #(
  parameter int StoreBytes = 2048
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cgtf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [cgtf_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              accept_i,
  input  wire logic [1:0]                        op_i,
  input  wire logic [cgtf_pkg::PalIdxW-1:0]      palette_index_i,
  input  wire logic [cgtf_pkg::ColorW-1:0]       color_word_i,
  input  wire logic [cgtf_pkg::ByteAddrW-1:0]    byte_address_i,
  input  wire logic [7:0]                        byte_value_i,
  input  wire logic [cgtf_pkg::CoordW-1:0]       dest_x_i,
  input  wire logic [cgtf_pkg::CoordW-1:0]       dest_y_i,
  output logic                                   ram_we_o,
  output logic [$clog2(StoreBytes)-1:0]          ram_waddr_o,
  output logic [7:0]                             ram_wdata_o,
  output logic                                   ram_re_o,
  output logic [$clog2(StoreBytes)-1:0]          ram_raddr_o,
  output cgtf_pkg::fetch_req_t                   fetch_o,
  output cgtf_pkg::pal_wr_t                      pal_wr_o
);
  import cgtf_pkg::*;

  localparam int AddrW = $clog2(StoreBytes);

  logic [SideW-1:0] width_q, height_q;
  logic             transposed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= SideW'(1);
      height_q     <= SideW'(1);
      transposed_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:      width_q      <= cfg_data_i;
        CFG_HEIGHT:     height_q     <= cfg_data_i;
        CFG_TRANSPOSED: transposed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  op_e               op;
  logic [SideW-1:0]  dst_w, dst_h;
  logic [CoordW-1:0] sx, sy;
  logic [7:0]        half_w;
  logic [SideW-1:0]  stride;
  logic [RowOffW-1:0] row_off;
  logic [FetchW-1:0] fetch_addr;
  logic [31:0]       fetch_addr_ext, byte_addr_ext;
  logic              beyond_store, outside;

  always_comb begin
    op       = op_e'(op_i);
    dst_w    = transposed_q ? height_q : width_q;
    dst_h    = transposed_q ? width_q : height_q;
    sx       = transposed_q ? dest_y_i : dest_x_i;
    sy       = transposed_q ? dest_x_i : dest_y_i;
    // row stride: pixel pairs rounded up to an even byte count
    half_w   = ((8'(width_q) + 8'd1) >> 1) + 8'd1;
    stride   = half_w[SideW-1:0] & ~SideW'(1);
    row_off  = RowOffW'(sy) * RowOffW'(stride);
    fetch_addr = FetchW'(row_off) + FetchW'(sx[CoordW-1:1]);
    fetch_addr_ext = 32'(fetch_addr);
    byte_addr_ext  = 32'(byte_address_i);
    beyond_store   = fetch_addr_ext >= 32'(StoreBytes);
    outside = ({1'b0, dest_x_i} >= dst_w) || ({1'b0, dest_y_i} >= dst_h) || beyond_store;

    ram_we_o    = accept_i && (op == OP_BMP_WR) && (byte_addr_ext < 32'(StoreBytes));
    ram_waddr_o = byte_addr_ext[AddrW-1:0];
    ram_wdata_o = byte_value_i;
    ram_re_o    = accept_i && (op == OP_FETCH) && !outside;
    ram_raddr_o = fetch_addr_ext[AddrW-1:0];

    fetch_o.fetch = accept_i && (op == OP_FETCH);
    fetch_o.oor   = outside;
    fetch_o.odd   = sx[0];

    pal_wr_o.wr    = accept_i && (op == OP_PAL_WR);
    pal_wr_o.idx   = palette_index_i;
    pal_wr_o.color = color_word_i;
  end

endmodule
`default_nettype wire

@@ hw/rtl/cgtf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgtf_back: palette lookup and result register
// Selects the nibble from the fetched byte, looks up the palette, widens
// the channels and registers the result. Palette writes go through a register
// before they land, so that fetches see exactly the earlier writes.
// ----------------------------------------------------------------------------
module cgtf_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cgtf_pkg::fetch_req_t          fetch_i,
  input  wire cgtf_pkg::pal_wr_t             pal_wr_i,
  input  wire logic [7:0]                    ram_rdata_i,
  output logic                               done_o,
  output logic [cgtf_pkg::ChanW-1:0]         red_o,
  output logic [cgtf_pkg::ChanW-1:0]         green_o,
  output logic [cgtf_pkg::ChanW-1:0]         blue_o,
  output logic [cgtf_pkg::ChanW-1:0]         alpha_o,
  output logic                               out_of_range_o
);
  import cgtf_pkg::*;

  fetch_req_t       fetch_q;
  pal_wr_t          pal_wr_q;
  logic [ColorW-1:0] palette_q [2**PalIdxW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_q  <= '0;
      pal_wr_q <= '0;
    end else begin
      fetch_q  <= fetch_i;
      pal_wr_q <= pal_wr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_wr_q.wr) begin
      palette_q[pal_wr_q.idx] <= pal_wr_q.color;
    end
  end

  logic [PalIdxW-1:0] nib;
  logic [ColorW-1:0]  color;
  logic [ChanW-1:0]   red_d, green_d, blue_d, alpha_d;

  always_comb begin
    nib   = fetch_q.odd ? ram_rdata_i[7:4] : ram_rdata_i[3:0];
    color = palette_q[nib];
    if (fetch_q.oor) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
      alpha_d = '0;
    end else begin
      red_d   = widen5(color[4:0]);
      green_d = widen5(color[9:5]);
      blue_d  = widen5(color[14:10]);
      alpha_d = (nib == '0) ? '0 : '1;
    end
  end

  logic             done_q, oor_q;
  logic [ChanW-1:0] red_q, green_q, blue_q, alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fetch_q.fetch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_q.fetch) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
      oor_q   <= fetch_q.oor;
    end
  end

  assign done_o         = done_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign alpha_o        = alpha_q;
  assign out_of_range_o = oor_q;

endmodule
`default_nettype wire

@@ hw/rtl/cgtf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgtf_checker: port-level checks for the texel fetch
// Result timing against fetch transfers and the shape of result values.
// ----------------------------------------------------------------------------
module cgtf_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic [1:0]                   op_i,
  input wire logic                         done_o,
  input wire logic [cgtf_pkg::ChanW-1:0]   red_o,
  input wire logic [cgtf_pkg::ChanW-1:0]   green_o,
  input wire logic [cgtf_pkg::ChanW-1:0]   blue_o,
  input wire logic [cgtf_pkg::ChanW-1:0]   alpha_o,
  input wire logic                         out_of_range_o
);
  import cgtf_pkg::*;

  logic [1:0] live_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      live_q <= {live_q[0], 1'b1};
    end
  end

  logic fetch_xfer;
  assign fetch_xfer = start_i && !busy_o && (op_i == OP_FETCH);

  a_result_per_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q[1] |-> (done_o == $past(fetch_xfer, 2)))
    else $error("result strobe does not match fetch transfer two cycles earlier");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |->
      (red_o == '0 && green_o == '0 && blue_o == '0 && alpha_o == '0))
    else $error("out-of-range result carries nonzero color");

  a_widened: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_of_range_o) |->
      ((alpha_o == '0 || alpha_o == '1) &&
       red_o[2:0] == red_o[7:5] && green_o[2:0] == green_o[7:5] &&
       blue_o[2:0] == blue_o[7:5]))
    else $error("result channels are not bit-replicated 5-bit values");

endmodule

bind clut4_glyph_texel_fetch_top cgtf_checker u_cgtf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .op_i          (op_i),
  .done_o        (done_o),
  .red_o         (red_o),
  .green_o       (green_o),
  .blue_o        (blue_o),
  .alpha_o       (alpha_o),
  .out_of_range_o(out_of_range_o)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the 4bpp palette glyph texel fetch
// A directed table covers the reset geometry, channel and alpha extremes,
// odd and even nibbles, transposition, zero sizes and fetches past the
// bitmap store; random phases then change the geometry and mix palette
// writes, bitmap writes, fetches and unused commands with random gaps.
// Texels are checked per field against table values or a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import cgtf_pkg::*;

  localparam int StoreBytes = 2048;
  localparam int CycleLimit = 500000;

  typedef struct packed {
    op_e                  op;
    logic [PalIdxW-1:0]   pidx;
    logic [ColorW-1:0]    color;
    logic [ByteAddrW-1:0] baddr;
    logic [7:0]           bval;
    logic [CoordW-1:0]    dx;
    logic [CoordW-1:0]    dy;
  } cmd_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             oor;
  } texel_t;

  typedef struct {
    bit                  is_reg;
    cfg_idx_e            ridx;
    logic [CfgDataW-1:0] rval;
    cmd_t                cmd;
    bit                  typed;
    texel_t              want;
  } step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [1:0]           op_i = '0;
  logic [PalIdxW-1:0]   palette_index_i = '0;
  logic [ColorW-1:0]    color_word_i = '0;
  logic [ByteAddrW-1:0] byte_address_i = '0;
  logic [7:0]           byte_value_i = '0;
  logic [CoordW-1:0]    dest_x_i = '0;
  logic [CoordW-1:0]    dest_y_i = '0;
  logic                 done_o;
  logic [ChanW-1:0]     red_o;
  logic [ChanW-1:0]     green_o;
  logic [ChanW-1:0]     blue_o;
  logic [ChanW-1:0]     alpha_o;
  logic                 out_of_range_o;

  clut4_glyph_texel_fetch_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .palette_index_i(palette_index_i),
    .color_word_i   (color_word_i),
    .byte_address_i (byte_address_i),
    .byte_value_i   (byte_value_i),
    .dest_x_i       (dest_x_i),
    .dest_y_i       (dest_y_i),
    .done_o         (done_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .out_of_range_o (out_of_range_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the block's stores and geometry
  logic [ColorW-1:0] pal_mem [16];
  bit                pal_set [16];
  logic [7:0]        bmp_mem [StoreBytes];
  bit                bmp_set [StoreBytes];
  logic [SideW-1:0]  geo_w = 7'd1;
  logic [SideW-1:0]  geo_h = 7'd1;
  bit                geo_t = 1'b0;

  texel_t pending_texels[$];
  step_t  dir_steps[$];
  int     errors = 0;
  int     cycles = 0;
  bit     burst = 1'b0;

  function automatic logic [ChanW-1:0] chan8(logic [4:0] c);
    return {c, 3'b000} | 8'(c >> 2);
  endfunction

  function automatic int stride_of();
    int w;
    w = int'(geo_w);
    return ((((w + 1) >> 1) + 1) >> 1) << 1;
  endfunction

  // source nibble address (byte * 2 + odd), -1 when outside glyph or store
  function automatic int src_nibble(int dx, int dy);
    int dw, dh, sx, sy, a;
    dw = geo_t ? int'(geo_h) : int'(geo_w);
    dh = geo_t ? int'(geo_w) : int'(geo_h);
    sx = geo_t ? dy : dx;
    sy = geo_t ? dx : dy;
    a  = sy * stride_of() + sx / 2;
    if (dx >= dw || dy >= dh || a >= StoreBytes) return -1;
    return 2 * a + sx % 2;
  endfunction

  function automatic texel_t predict_texel(int dx, int dy);
    int n;
    logic [7:0] b;
    logic [3:0] k;
    logic [ColorW-1:0] col;
    texel_t p;
    p = '0;
    n = src_nibble(dx, dy);
    if (n < 0) begin
      p.oor = 1'b1;
      return p;
    end
    b = bmp_mem[n / 2];
    k = (n % 2 != 0) ? b[7:4] : b[3:0];
    col = pal_mem[k];
    p.red   = chan8(col[4:0]);
    p.green = chan8(col[9:5]);
    p.blue  = chan8(col[14:10]);
    p.alpha = (k == 4'd0) ? 8'd0 : 8'd255;
    return p;
  endfunction

  function automatic cmd_t rand_cmd(op_e op);
    cmd_t c;
    c.op    = op;
    c.pidx  = PalIdxW'($urandom_range(0, 15));
    c.color = ColorW'($urandom_range(0, 65535));
    c.baddr = ByteAddrW'($urandom_range(0, StoreBytes - 1));
    c.bval  = 8'($urandom_range(0, 255));
    c.dx    = CoordW'($urandom_range(0, 63));
    c.dy    = CoordW'($urandom_range(0, 63));
    return c;
  endfunction

  function automatic cmd_t pal_cmd(int idx, int color);
    cmd_t c;
    c = rand_cmd(OP_PAL_WR);
    c.pidx = PalIdxW'(idx);
    c.color = ColorW'(color);
    return c;
  endfunction

  function automatic cmd_t bmp_cmd(int addr, int val);
    cmd_t c;
    c = rand_cmd(OP_BMP_WR);
    c.baddr = ByteAddrW'(addr);
    c.bval = 8'(val);
    return c;
  endfunction

  function automatic cmd_t fetch_cmd(int x, int y);
    cmd_t c;
    c = rand_cmd(OP_FETCH);
    c.dx = CoordW'(x);
    c.dy = CoordW'(y);
    return c;
  endfunction

  function automatic step_t st_cmd(cmd_t c);
    step_t s;
    s.is_reg = 1'b0;
    s.ridx = CFG_NONE;
    s.rval = '0;
    s.cmd = c;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t st_reg(cfg_idx_e i, int v);
    step_t s;
    s = st_cmd(rand_cmd(OP_NOP));
    s.is_reg = 1'b1;
    s.ridx = i;
    s.rval = CfgDataW'(v);
    return s;
  endfunction

  function automatic step_t fetch_is(int x, int y, int r, int g, int b, int a, bit o);
    step_t s;
    s = st_cmd(fetch_cmd(x, y));
    s.typed = 1'b1;
    s.want.red = ChanW'(r);
    s.want.green = ChanW'(g);
    s.want.blue = ChanW'(b);
    s.want.alpha = ChanW'(a);
    s.want.oor = o;
    return s;
  endfunction

  task automatic wait_idle();
    if (start_i) start_i <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH:      geo_w = val;
      CFG_HEIGHT:     geo_h = val;
      CFG_TRANSPOSED: geo_t = val[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int w, int h, bit t);
    wait_idle();
    cfg_write(CFG_WIDTH, CfgDataW'(w));
    cfg_write(CFG_HEIGHT, CfgDataW'(h));
    cfg_write(CFG_TRANSPOSED, {6'($urandom_range(0, 63)), t});
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_NONE, CfgDataW'($urandom_range(0, 127)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_cmd(cmd_t c, bit typed, texel_t want);
    texel_t p;
    int gap;
    start_i <= 1'b1;
    op_i <= c.op;
    palette_index_i <= c.pidx;
    color_word_i <= c.color;
    byte_address_i <= c.baddr;
    byte_value_i <= c.bval;
    dest_x_i <= c.dx;
    dest_y_i <= c.dy;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (c.op)
      OP_PAL_WR: begin
        pal_mem[c.pidx] = c.color;
        pal_set[c.pidx] = 1'b1;
      end
      OP_BMP_WR: begin
        bmp_mem[c.baddr] = c.bval;
        bmp_set[c.baddr] = 1'b1;
      end
      OP_FETCH: begin
        p = predict_texel(c.dx, c.dy);
        pending_texels.push_back(typed ? want : p);
      end
      default: ;
    endcase
    gap = (burst || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // fetches only touch written entries: missing ones are written first
  task automatic fetch_with_fill(int x, int y);
    int n;
    logic [7:0] b;
    logic [3:0] k;
    n = src_nibble(x, y);
    if (n >= 0) begin
      if (!bmp_set[n / 2]) send_cmd(bmp_cmd(n / 2, $urandom_range(0, 255)), 1'b0, '0);
      b = bmp_mem[n / 2];
      k = (n % 2 != 0) ? b[7:4] : b[3:0];
      if (!pal_set[k]) send_cmd(pal_cmd(int'(k), $urandom_range(0, 65535)), 1'b0, '0);
    end
    send_cmd(fetch_cmd(x, y), 1'b0, '0);
  endtask

  task automatic random_item();
    int r, x, y, dw, dh, area;
    r = $urandom_range(0, 99);
    dw = geo_t ? int'(geo_h) : int'(geo_w);
    dh = geo_t ? int'(geo_w) : int'(geo_h);
    if ($urandom_range(0, 49) == 0) wait_idle();
    if (r < 8) begin
      send_cmd(pal_cmd($urandom_range(0, 15), $urandom_range(0, 65535)), 1'b0, '0);
    end else if (r < 38) begin
      area = stride_of() * int'(geo_h);
      if (area > StoreBytes) area = StoreBytes;
      if (area > 0 && $urandom_range(0, 9) < 7) x = $urandom_range(0, area - 1);
      else x = $urandom_range(0, StoreBytes - 1);
      send_cmd(bmp_cmd(x, $urandom_range(0, 255)), 1'b0, '0);
    end else if (r < 96) begin
      if (dw > 0 && dh > 0 && $urandom_range(0, 9) < 8) begin
        x = $urandom_range(0, (dw > 64 ? 64 : dw) - 1);
        y = $urandom_range(0, (dh > 64 ? 64 : dh) - 1);
      end else begin
        x = $urandom_range(0, 63);
        y = $urandom_range(0, 63);
      end
      fetch_with_fill(x, y);
    end else begin
      send_cmd(rand_cmd(OP_NOP), 1'b0, '0);
    end
  endtask

  task automatic build_directed();
    cmd_t all_ones;
    all_ones = '1;
    dir_steps.push_back(st_cmd(pal_cmd(0, 16'hFFFF)));
    dir_steps.push_back(st_cmd(pal_cmd(15, 16'h7FFF)));
    dir_steps.push_back(st_cmd(pal_cmd(1, 16'h8000)));
    dir_steps.push_back(st_cmd(pal_cmd(2, 16'h001F)));
    dir_steps.push_back(st_cmd(pal_cmd(3, 16'h03E0)));
    dir_steps.push_back(st_cmd(pal_cmd(4, 16'h7C00)));
    dir_steps.push_back(st_cmd(bmp_cmd(0, 8'hF0)));
    dir_steps.push_back(st_cmd(bmp_cmd(StoreBytes - 1, 8'h12)));
    dir_steps.push_back(st_cmd(all_ones));
    // reset geometry is 1x1
    dir_steps.push_back(fetch_is(0, 0, 255, 255, 255, 0, 1'b0));
    dir_steps.push_back(fetch_is(1, 0, 0, 0, 0, 0, 1'b1));
    dir_steps.push_back(fetch_is(0, 1, 0, 0, 0, 0, 1'b1));
    dir_steps.push_back(fetch_is(63, 63, 0, 0, 0, 0, 1'b1));
    dir_steps.push_back(st_reg(CFG_WIDTH, 2));
    dir_steps.push_back(fetch_is(1, 0, 255, 255, 255, 255, 1'b0));
    dir_steps.push_back(st_reg(CFG_WIDTH, 64));
    dir_steps.push_back(st_reg(CFG_HEIGHT, 64));
    // last byte of the store
    dir_steps.push_back(fetch_is(63, 63, 0, 0, 0, 255, 1'b0));
    dir_steps.push_back(fetch_is(62, 63, 255, 0, 0, 255, 1'b0));
    dir_steps.push_back(st_cmd(bmp_cmd(33, 8'h43)));
    dir_steps.push_back(st_cmd(fetch_cmd(2, 1)));
    dir_steps.push_back(st_cmd(fetch_cmd(3, 1)));
    dir_steps.push_back(st_reg(CFG_TRANSPOSED, 1));
    dir_steps.push_back(st_cmd(fetch_cmd(1, 2)));
    dir_steps.push_back(fetch_is(0, 0, 255, 255, 255, 0, 1'b0));
    // zero width: transposed height is zero
    dir_steps.push_back(st_reg(CFG_WIDTH, 0));
    dir_steps.push_back(fetch_is(0, 0, 0, 0, 0, 0, 1'b1));
    dir_steps.push_back(st_reg(CFG_TRANSPOSED, 0));
    dir_steps.push_back(st_reg(CFG_WIDTH, 127));
    dir_steps.push_back(st_reg(CFG_NONE, 127));
    // row 63 at stride 64 lies past the store
    dir_steps.push_back(fetch_is(0, 63, 0, 0, 0, 0, 1'b1));
    dir_steps.push_back(fetch_is(0, 0, 255, 255, 255, 0, 1'b0));
  endtask

  always @(posedge clk_i) begin : check_texel
    texel_t e;
    if (rst_ni && done_o) begin
      if (pending_texels.size() == 0) begin
        $error("texel transfer with no fetch pending");
        errors++;
      end else begin
        e = pending_texels.pop_front();
        if (red_o !== e.red) begin
          $error("red: expected %0d, got %0d", e.red, red_o);
          errors++;
        end
        if (green_o !== e.green) begin
          $error("green: expected %0d, got %0d", e.green, green_o);
          errors++;
        end
        if (blue_o !== e.blue) begin
          $error("blue: expected %0d, got %0d", e.blue, blue_o);
          errors++;
        end
        if (alpha_o !== e.alpha) begin
          $error("alpha: expected %0d, got %0d", e.alpha, alpha_o);
          errors++;
        end
        if (out_of_range_o !== e.oor) begin
          $error("out_of_range: expected %0d, got %0d", e.oor, out_of_range_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int ph, w, h;
    bit t, prev_reg;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed();
    prev_reg = 1'b0;
    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_reg) begin
        if (!prev_reg) wait_idle();
        cfg_write(dir_steps[i].ridx, dir_steps[i].rval);
        prev_reg = 1'b1;
      end else begin
        if (prev_reg) cfg_we_i <= 1'b0;
        send_cmd(dir_steps[i].cmd, dir_steps[i].typed, dir_steps[i].want);
        prev_reg = 1'b0;
      end
    end

    for (ph = 0; ph < 12; ph++) begin
      t = 1'($urandom_range(0, 1));
      case (ph)
        0: begin w = 64; h = 64; t = 1'b0; end
        1: begin w = 64; h = 64; t = 1'b1; end
        2: begin w = 0; h = $urandom_range(1, 64); end
        3: begin w = $urandom_range(1, 64); h = 0; end
        4: begin w = 127; h = 127; end
        5: begin w = 1; h = 1; t = 1'b0; end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 64);
          end else begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
          end
        end
      endcase
      set_geometry(w, h, t);
      burst = (ph % 4 == 3);
      repeat (55) random_item();
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_texels.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
